[hdl/hbmt_pkg.sv]
// Shared types, codes and helpers of the heartbeat membership table.
`timescale 1ns / 1ps
package hbmt_pkg;

	localparam int TABLE_DEPTH_DEF = 32;

	typedef enum logic [1:0] {
		FN_TICK   = 2'd0,
		FN_JREQ   = 2'd1,
		FN_JREP   = 2'd2,
		FN_GOSSIP = 2'd3
	} func_t;

	localparam logic [2:0] ST_TICK       = 3'd0;
	localparam logic [2:0] ST_UPDATED    = 3'd1;
	localparam logic [2:0] ST_UNCHANGED  = 3'd2;
	localparam logic [2:0] ST_APPENDED   = 3'd3;
	localparam logic [2:0] ST_STALE      = 3'd4;
	localparam logic [2:0] ST_FULL       = 3'd5;
	localparam logic [2:0] ST_NOT_JOINED = 3'd6;
	localparam logic [2:0] ST_OWN_ID     = 3'd7;

	localparam logic [2:0] REG_OWN_ID     = 3'd0;
	localparam logic [2:0] REG_OWN_PORT   = 3'd1;
	localparam logic [2:0] REG_INTRO_ID   = 3'd2;
	localparam logic [2:0] REG_FAIL_LIM   = 3'd3;
	localparam logic [2:0] REG_REMOVE_LIM = 3'd4;

	typedef struct packed {
		logic [31:0] id;
		logic [15:0] port;
		logic [31:0] beat;
		logic [31:0] stamp;
	} entry_t;

	typedef struct packed {
		func_t  func;
		logic   own_match;
		entry_t ent;
	} item_t;

	typedef struct packed {
		logic [31:0] own_id;
		logic [15:0] fail_limit;
		logic [15:0] remove_limit;
		logic        join_set;
	} cfg_t;

	// True when tick - stamp, both signed, exceeds the unsigned limit.
	function automatic logic age_over(input logic [31:0] tick, input logic [31:0] stamp,
			input logic [15:0] limit);
		logic signed [33:0] diff;
		diff = $signed({{2{tick[31]}}, tick}) - $signed({{2{stamp[31]}}, stamp});
		return diff > $signed({18'd0, limit});
	endfunction

endpackage

[hdl/hbmt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hbmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[hdl/hbmt_front.sv]
// Front end: accepts items, classifies them and holds them in a two-entry queue.
`timescale 1ns / 1ps
module hbmt_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid,
	output logic           stall,
	input  logic [1:0]     func,
	input  logic [31:0]    member_id,
	input  logic [15:0]    member_port,
	input  logic [31:0]    member_beat,
	input  logic [31:0]    member_stamp,
	input  logic [31:0]    own_id,
	output logic           q_valid,
	output hbmt_pkg::item_t q_item,
	input  logic           q_pop
);
	import hbmt_pkg::*;

	item_t      slot_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	item_t      item_in;
	logic       push;

	always_comb begin
		item_in.func      = func_t'(func);
		item_in.own_match = (member_id == own_id);
		item_in.ent.id    = member_id;
		item_in.ent.port  = member_port;
		item_in.ent.beat  = member_beat;
		item_in.ent.stamp = member_stamp;
	end

	assign stall   = (cnt_q == 2'd2);
	assign push    = valid && !stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (q_pop) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

[hdl/hbmt_back.sv]
// Back end: carries out ticks and entries against the table and registers the result.
`timescale 1ns / 1ps
module hbmt_back #(
	parameter int DEPTH = hbmt_pkg::TABLE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  hbmt_pkg::cfg_t             cfg,
	input  logic                       q_valid,
	input  hbmt_pkg::item_t            q_item,
	output logic                       q_pop,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [2:0]                 status,
	output logic                       removed,
	output logic [31:0]                removed_id,
	output logic [31:0]                own_beat,
	output logic [$clog2(DEPTH+1)-1:0] entry_total
);
	import hbmt_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD   = 5'b00010,
		S_CHK  = 5'b00100,
		S_SHW  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t         state_q;
	item_t          item_q;
	logic [AW-1:0]  idx_q;
	logic [CW-1:0]  cnt_q;
	logic [31:0]    tick_q, beat_q, beat0_q;
	logic           joined_q, bump_q;
	logic [2:0]     st_q;
	logic           rem_q;
	logic [31:0]    rid_q;

	logic           we;
	logic [AW-1:0]  waddr, raddr;
	entry_t         wdata, rdata;
	logic [CW:0]    idx_ext;
	logic           last, hit, full, stale, out_free, walk;

	hbmt_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign idx_ext  = {{(CW + 1 - AW){1'b0}}, idx_q};
	assign last     = (idx_ext + 1'b1) >= {1'b0, cnt_q};
	assign full     = (cnt_q == CW'(DEPTH));
	assign stale    = age_over(tick_q, q_item.ent.stamp, cfg.fail_limit);
	assign hit      = (item_q.func == FN_TICK) ? age_over(tick_q, rdata.stamp, cfg.remove_limit)
	                                           : (rdata.id == item_q.ent.id);
	assign out_free = !rsp_valid || !rsp_stall;
	assign q_pop    = (state_q == S_IDLE) && q_valid;
	// The table beyond the own entry is walked by a joined tick and by fresh gossip
	// about another member.
	assign walk     = joined_q && (cnt_q > CW'(1)) && ((q_item.func == FN_TICK) ||
	                  (q_item.func == FN_GOSSIP && !stale && !q_item.own_match));

	always_comb begin
		unique case (state_q)
			S_CHK:   raddr = AW'(idx_ext + 2'd1);
			S_SHW:   raddr = AW'(idx_ext + 2'd2);
			default: raddr = idx_q;
		endcase
	end

	// Write port: appends, gossip refreshes and the shift that closes a removal gap.
	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[AW-1:0];
		wdata = q_item.ent;
		priority if (q_pop && !full && ((q_item.func == FN_JREQ) ||
				(q_item.func == FN_JREP && !q_item.own_match))) begin
			we = 1'b1;
		end else if (q_pop && !full && q_item.func == FN_GOSSIP && joined_q && !stale &&
				!q_item.own_match && cnt_q == CW'(1)) begin
			we = 1'b1;
		end else if (state_q == S_CHK && item_q.func == FN_GOSSIP) begin
			if (hit && item_q.ent.beat > rdata.beat) begin
				we    = 1'b1;
				waddr = idx_q;
				wdata = '{id: rdata.id, port: rdata.port, beat: item_q.ent.beat,
				          stamp: tick_q};
			end else if (!hit && last && !full) begin
				we    = 1'b1;
				wdata = item_q.ent;
			end
		end else if (state_q == S_SHW) begin
			we    = 1'b1;
			waddr = idx_q;
			wdata = rdata;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			cnt_q       <= CW'(1);
			tick_q      <= '1;
			beat_q      <= '0;
			beat0_q     <= '0;
			joined_q    <= 1'b0;
			bump_q      <= 1'b0;
			st_q        <= ST_TICK;
			rem_q       <= 1'b0;
			rid_q       <= '0;
			rsp_valid   <= 1'b0;
			status      <= ST_TICK;
			removed     <= 1'b0;
			removed_id  <= '0;
			own_beat    <= '0;
			entry_total <= CW'(1);
		end else begin
			if (cfg.join_set || (q_pop && q_item.func == FN_JREP)) begin
				joined_q <= 1'b1;
			end
			if (rsp_valid && !rsp_stall && state_q != S_OUT) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						rem_q   <= 1'b0;
						rid_q   <= '0;
						bump_q  <= (q_item.func == FN_TICK) && joined_q;
						idx_q   <= AW'(1);
						state_q <= walk ? S_RD : S_OUT;
						unique case (q_item.func)
							FN_TICK: begin
								if (!joined_q) begin
									st_q <= ST_NOT_JOINED;
								end else begin
									st_q    <= ST_TICK;
									beat_q  <= beat_q + 32'd1;
									beat0_q <= beat_q + 32'd1;
								end
							end
							FN_JREQ, FN_JREP: begin
								if (q_item.func == FN_JREP && q_item.own_match) begin
									st_q <= ST_OWN_ID;
								end else if (full) begin
									st_q <= ST_FULL;
								end else begin
									st_q  <= ST_APPENDED;
									cnt_q <= cnt_q + 1'b1;
								end
							end
							FN_GOSSIP: begin
								if (!joined_q) begin
									st_q <= ST_NOT_JOINED;
								end else if (stale) begin
									st_q <= ST_STALE;
								end else if (q_item.own_match) begin
									if (q_item.ent.beat > beat0_q) begin
										beat0_q <= q_item.ent.beat;
										st_q    <= ST_UPDATED;
									end else begin
										st_q <= ST_UNCHANGED;
									end
								end else if (!walk) begin
									if (full) begin
										st_q <= ST_FULL;
									end else begin
										st_q  <= ST_APPENDED;
										cnt_q <= cnt_q + 1'b1;
									end
								end
							end
							default: st_q <= ST_TICK;
						endcase
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (item_q.func == FN_TICK) begin
						if (hit) begin
							rem_q <= 1'b1;
							rid_q <= rdata.id;
							if (last) begin
								cnt_q   <= cnt_q - 1'b1;
								state_q <= S_OUT;
							end else begin
								state_q <= S_SHW;
							end
						end else if (last) begin
							state_q <= S_OUT;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						if (hit) begin
							st_q    <= (item_q.ent.beat > rdata.beat) ? ST_UPDATED
							                                          : ST_UNCHANGED;
							state_q <= S_OUT;
						end else if (last) begin
							if (full) begin
								st_q <= ST_FULL;
							end else begin
								st_q  <= ST_APPENDED;
								cnt_q <= cnt_q + 1'b1;
							end
							state_q <= S_OUT;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_SHW: begin
					if ((idx_ext + 2'd2) < {1'b0, cnt_q}) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						rsp_valid   <= 1'b1;
						status      <= st_q;
						removed     <= rem_q;
						removed_id  <= rid_q;
						own_beat    <= beat_q;
						entry_total <= cnt_q;
						if (bump_q) begin
							tick_q <= tick_q + 32'd1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q >= CW'(1)) && (cnt_q <= CW'(DEPTH)))
		else $error("table count out of range");
	a_rsp_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output step");
	a_removed_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && removed) |-> (status == ST_TICK))
		else $error("removal reported for a non-tick item");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q != S_IDLE))
		else $error("item popped without leaving idle");
`endif
endmodule

[hdl/heartbeat_membership_table.sv]
// Top level of the heartbeat membership table: config registers, front end and back end.
`timescale 1ns / 1ps
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  request  | req_valid, req_stall | func, member_id, member_port, member_beat,
//           |                      | member_stamp
//  response | rsp_valid, rsp_stall | status, removed, removed_id, own_beat,
//           |                      | entry_total
//  config   | APB psel/penable     | paddr, pwdata, prdata (own_id .. remove_limit)
//
// An item is registered in the front queue before the back end pops it. A tick, or fresh
// gossip about another member, when joined and while the table holds more than the own
// entry, then goes through pop, a RAM read, a check per entry scanned, a move per entry
// moved up after a removal, and the load of the result; every other item goes from pop
// straight to load. The walk is bound by the single read port of the table RAM.
// Reset clears control state only; no clearing pass runs, the own entry is kept in
// registers and the RAM slots become meaningful as they are appended.
// The front queue holds two items, so up to two requests are taken while the back end
// works or while a finished result waits under rsp_stall.
module heartbeat_membership_table #(
	parameter int TABLE_DEPTH = hbmt_pkg::TABLE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic [1:0]                       func,
	input  logic [31:0]                      member_id,
	input  logic [15:0]                      member_port,
	input  logic [31:0]                      member_beat,
	input  logic [31:0]                      member_stamp,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic [2:0]                       status,
	output logic                             removed,
	output logic [31:0]                      removed_id,
	output logic [31:0]                      own_beat,
	output logic [$clog2(TABLE_DEPTH+1)-1:0] entry_total,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [4:0]                       paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import hbmt_pkg::*;

	logic [31:0] own_id_q, intro_id_q;
	logic [15:0] own_port_q, fail_lim_q, remove_lim_q;
	logic        wr_en;
	logic [2:0]  reg_idx;
	cfg_t        cfg;
	logic        q_valid, q_pop;
	item_t       q_item;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	// A register write sets joined when it makes the two ids equal; it never clears it.
	assign cfg.own_id       = own_id_q;
	assign cfg.fail_limit   = fail_lim_q;
	assign cfg.remove_limit = remove_lim_q;
	assign cfg.join_set     = wr_en && (((reg_idx == REG_OWN_ID) && (pwdata == intro_id_q)) ||
	                          ((reg_idx == REG_INTRO_ID) && (pwdata == own_id_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q     <= 32'd0;
			own_port_q   <= 16'd0;
			intro_id_q   <= 32'd1;
			fail_lim_q   <= 16'd5;
			remove_lim_q <= 16'd20;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_OWN_ID:     own_id_q     <= pwdata;
				REG_OWN_PORT:   own_port_q   <= pwdata[15:0];
				REG_INTRO_ID:   intro_id_q   <= pwdata;
				REG_FAIL_LIM:   fail_lim_q   <= pwdata[15:0];
				REG_REMOVE_LIM: remove_lim_q <= pwdata[15:0];
				default:        own_id_q     <= own_id_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_OWN_ID:     prdata = own_id_q;
			REG_OWN_PORT:   prdata = {16'd0, own_port_q};
			REG_INTRO_ID:   prdata = intro_id_q;
			REG_FAIL_LIM:   prdata = {16'd0, fail_lim_q};
			REG_REMOVE_LIM: prdata = {16'd0, remove_lim_q};
			default:        prdata = 32'd0;
		endcase
	end

	hbmt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (req_valid),
		.stall        (req_stall),
		.func         (func),
		.member_id    (member_id),
		.member_port  (member_port),
		.member_beat  (member_beat),
		.member_stamp (member_stamp),
		.own_id       (own_id_q),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop)
	);

	hbmt_back #(.DEPTH(TABLE_DEPTH)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.removed     (removed),
		.removed_id  (removed_id),
		.own_beat    (own_beat),
		.entry_total (entry_total)
	);
endmodule

[sim/tb_heartbeat_membership_table.sv]
// Self-checking testbench of the heartbeat membership table.
`timescale 1ns / 1ps
module tb_heartbeat_membership_table;
	import hbmt_pkg::*;

	localparam int DEPTH      = 32;
	// Longest item: pop, RAM read, a scan of the full table, a move of the full table and a load.
	localparam int DRAIN_WAIT = 2 * DEPTH + 40;
	localparam int STUCK_MAX  = 5000;
	localparam int RAND_ITEMS = 1900;
	localparam int PHASES     = 6;

	// One result of the block, in the order of its output ports.
	typedef struct packed {
		logic [2:0]  status;
		logic        removed;
		logic [31:0] removed_id;
		logic [31:0] own_beat;
		logic [5:0]  entry_total;
	} outcome_t;

	// One row of the directed table; typed rows carry the status that must come back.
	typedef struct {
		func_t       fn;
		logic [31:0] id;
		logic [15:0] port;
		logic [31:0] beat;
		logic [31:0] stamp;
		bit          typed;
		logic [2:0]  st;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [1:0]  func;
	logic [31:0] member_id;
	logic [15:0] member_port;
	logic [31:0] member_beat;
	logic [31:0] member_stamp;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [2:0]  status;
	logic        removed;
	logic [31:0] removed_id;
	logic [31:0] own_beat;
	logic [5:0]  entry_total;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	heartbeat_membership_table #(.TABLE_DEPTH(DEPTH)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .func(func),
		.member_id(member_id), .member_port(member_port),
		.member_beat(member_beat), .member_stamp(member_stamp),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .status(status),
		.removed(removed), .removed_id(removed_id), .own_beat(own_beat),
		.entry_total(entry_total),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Shadow of the membership table and its registers, kept by the predictor below.
	logic [31:0] tbl_id    [DEPTH];
	logic [15:0] tbl_port  [DEPTH];
	logic [31:0] tbl_beat  [DEPTH];
	logic [31:0] tbl_stamp [DEPTH];
	int          tbl_count;
	logic [31:0] tick_ctr;
	logic [31:0] beat_ctr;
	bit          is_joined;
	logic [31:0] cfg_own_id;
	logic [15:0] cfg_own_port;
	logic [31:0] cfg_intro_id;
	logic [15:0] cfg_fail_lim;
	logic [15:0] cfg_remove_lim;

	outcome_t pending_results[$];
	row_t     dir_rows[$];
	int       errors;
	int       burst_left;
	bit       hold_long;

	// The clock runs freely from time zero.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Age of a stamp against the tick counter, both signed, taken without wrap.
	function automatic bit older_than(input logic [31:0] stamp, input logic [15:0] limit);
		longint age;
		age = longint'($signed(tick_ctr)) - longint'($signed(stamp));
		return age > longint'({48'd0, limit});
	endfunction

	// Appends one member at the end of the table, or reports the table as full.
	function automatic logic [2:0] table_append(input logic [31:0] id, input logic [15:0] port,
			input logic [31:0] beat, input logic [31:0] stamp);
		if (tbl_count >= DEPTH)
			return ST_FULL;
		tbl_id[tbl_count]    = id;
		tbl_port[tbl_count]  = port;
		tbl_beat[tbl_count]  = beat;
		tbl_stamp[tbl_count] = stamp;
		tbl_count++;
		return ST_APPENDED;
	endfunction

	// Applies one accepted item to the shadow table and returns the result it must produce.
	function automatic outcome_t membership_step(input func_t fn, input logic [31:0] id,
			input logic [15:0] port, input logic [31:0] beat, input logic [31:0] stamp);
		outcome_t o;
		bit       found;
		o = '0;
		case (fn)
			FN_TICK: begin
				if (!is_joined) begin
					o.status = ST_NOT_JOINED;
				end else begin
					// The own entry is stamped first, so it can never expire.
					tbl_stamp[0] = tick_ctr;
					beat_ctr = beat_ctr + 32'd1;
					tbl_beat[0] = beat_ctr;
					for (int i = 0; i < tbl_count; i++) begin
						if (older_than(tbl_stamp[i], cfg_remove_lim)) begin
							o.removed = 1'b1;
							o.removed_id = tbl_id[i];
							for (int j = i; j + 1 < tbl_count; j++) begin
								tbl_id[j]    = tbl_id[j + 1];
								tbl_port[j]  = tbl_port[j + 1];
								tbl_beat[j]  = tbl_beat[j + 1];
								tbl_stamp[j] = tbl_stamp[j + 1];
							end
							tbl_count--;
							break;
						end
					end
					tick_ctr = tick_ctr + 32'd1;
					o.status = ST_TICK;
				end
			end
			FN_JREQ: o.status = table_append(id, port, beat, stamp);
			FN_JREP: begin
				// A reply that names this node is only a join, never an append.
				if (id == cfg_own_id)
					o.status = ST_OWN_ID;
				else
					o.status = table_append(id, port, beat, stamp);
				is_joined = 1'b1;
			end
			default: begin
				if (!is_joined) begin
					o.status = ST_NOT_JOINED;
				end else if (older_than(stamp, cfg_fail_lim)) begin
					o.status = ST_STALE;
				end else begin
					found = 1'b0;
					o.status = ST_UNCHANGED;
					for (int i = 0; i < tbl_count; i++) begin
						if (tbl_id[i] == id) begin
							found = 1'b1;
							if (beat > tbl_beat[i]) begin
								tbl_beat[i] = beat;
								tbl_stamp[i] = tick_ctr;
								o.status = ST_UPDATED;
							end
							break;
						end
					end
					if (!found)
						o.status = table_append(id, port, beat, stamp);
				end
			end
		endcase
		o.own_beat = beat_ctr;
		o.entry_total = 6'(tbl_count);
		return o;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t ns: %s is %0h, expected %0h", $time, what, got, want);
		errors++;
	endtask

	// One register write through the APB port, mirrored into the shadow registers.
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_OWN_ID: begin
				cfg_own_id = value;
				tbl_id[0] = value;
			end
			REG_OWN_PORT: begin
				cfg_own_port = value[15:0];
				tbl_port[0] = value[15:0];
			end
			REG_INTRO_ID: cfg_intro_id = value;
			REG_FAIL_LIM: cfg_fail_lim = value[15:0];
			default: cfg_remove_lim = value[15:0];
		endcase
		// Writing either id joins the group once they agree, and never leaves it.
		if ((idx == REG_OWN_ID || idx == REG_INTRO_ID) && cfg_own_id == cfg_intro_id)
			is_joined = 1'b1;
	endtask

	// Offers one item, holds it until taken, then records the result it must cause.
	task automatic offer_item(input func_t fn, input logic [31:0] id, input logic [15:0] port,
			input logic [31:0] beat, input logic [31:0] stamp, input bit typed,
			input logic [2:0] st);
		outcome_t o;
		int       gap;
		// The sender works in bursts; a gap closes each one.
		if (burst_left == 0) begin
			gap = $urandom_range(1, 7);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 8);
		end
		burst_left--;
		req_valid <= 1'b1;
		func <= fn;
		member_id <= id;
		member_port <= port;
		member_beat <= beat;
		member_stamp <= stamp;
		do @(posedge clk); while (req_stall);
		o = membership_step(fn, id, port, beat, stamp);
		if (typed)
			o.status = st;
		pending_results = {pending_results, o};
	endtask

	task automatic add_row(input func_t fn, input logic [31:0] id, input logic [15:0] port,
			input logic [31:0] beat, input logic [31:0] stamp, input bit typed,
			input logic [2:0] st);
		row_t r;
		r.fn = fn;
		r.id = id;
		r.port = port;
		r.beat = beat;
		r.stamp = stamp;
		r.typed = typed;
		r.st = st;
		dir_rows = {dir_rows, r};
	endtask

	// Lowers valid and waits until every result has arrived and the block has gone quiet.
	task automatic drain;
		req_valid <= 1'b0;
		burst_left = 0;
		wait (pending_results.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Random item, mostly well formed: known ids, fresh stamps, heartbeats that move up.
	task automatic offer_random;
		int          pick;
		func_t       fn;
		logic [31:0] id;
		logic [31:0] beat;
		logic [31:0] stamp;
		pick = $urandom_range(0, 99);
		id = (tbl_count > 0 && $urandom_range(0, 2) != 0)
			? tbl_id[$urandom_range(0, tbl_count - 1)] : $urandom();
		beat = ($urandom_range(0, 3) == 0) ? $urandom() : beat_ctr + $urandom_range(0, 20)
			- 32'd10;
		stamp = ($urandom_range(0, 4) == 0) ? $urandom()
			: tick_ctr - $urandom_range(0, cfg_fail_lim > 30 ? 30 : cfg_fail_lim + 2)
				+ 32'($urandom_range(0, 1));
		if (pick < 18)
			fn = FN_TICK;
		else if (pick < 33)
			fn = FN_JREQ;
		else if (pick < 41)
			fn = FN_JREP;
		else
			fn = FN_GOSSIP;
		if (fn == FN_JREP && $urandom_range(0, 3) == 0)
			id = cfg_own_id;
		offer_item(fn, id, 16'($urandom()), beat, stamp, 1'b0, ST_TICK);
	endtask

	// The receiver stalls on a changing pattern, and once holds off for a long stretch.
	initial begin
		int mode;
		int len;
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				rsp_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_long = 1'b0;
			end
			mode = $urandom_range(0, 3);
			len = $urandom_range(5, 60);
			for (int k = 0; k < len; k++) begin
				case (mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 9) < 3);
					2: rsp_stall <= (k % 3 == 0);
					default: rsp_stall <= ($urandom_range(0, 9) < 7);
				endcase
				@(posedge clk);
			end
		end
	end

	// Each result taken from the block is compared with the oldest expectation.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				report("unexpected result, status", 32'(status), 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report("status", 32'(status), 32'(want.status));
				if (removed !== want.removed)
					report("removed", 32'(removed), 32'(want.removed));
				if (removed_id !== want.removed_id)
					report("removed_id", removed_id, want.removed_id);
				if (own_beat !== want.own_beat)
					report("own_beat", own_beat, want.own_beat);
				if (entry_total !== want.entry_total)
					report("entry_total", 32'(entry_total), 32'(want.entry_total));
			end
		end
	end

	// The run is stopped when neither channel moves for far too long.
	initial begin
		int stuck;
		stuck = 0;
		forever begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				stuck = 0;
			else
				stuck++;
			if (stuck >= STUCK_MAX) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] own_ids    [PHASES];
		logic [15:0] fail_lims  [PHASES];
		logic [15:0] remove_lims[PHASES];
		int          per_phase;
		errors = 0;
		burst_left = 0;
		hold_long = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		func = FN_TICK;
		member_id = '0;
		member_port = '0;
		member_beat = '0;
		member_stamp = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;

		// Shadow state as reset leaves it; the node starts outside the group.
		for (int i = 0; i < DEPTH; i++) begin
			tbl_id[i] = '0;
			tbl_port[i] = '0;
			tbl_beat[i] = '0;
			tbl_stamp[i] = '0;
		end
		tbl_stamp[0] = 32'hFFFF_FFFF;
		tbl_count = 1;
		tick_ctr = 32'hFFFF_FFFF;
		beat_ctr = '0;
		is_joined = 1'b0;
		cfg_own_id = '0;
		cfg_own_port = '0;
		cfg_intro_id = 32'd1;
		cfg_fail_lim = 16'd5;
		cfg_remove_lim = 16'd20;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, run on the reset settings.
		// Before any join, ticks and gossip are refused.
		add_row(FN_TICK, 32'd0, 16'd0, 32'd0, 32'd0, 1'b1, ST_NOT_JOINED);
		add_row(FN_GOSSIP, 32'd5, 16'd1, 32'd1, 32'd0, 1'b1, ST_NOT_JOINED);
		// Join requests append even while outside the group; extreme fields.
		add_row(FN_JREQ, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1,
			ST_APPENDED);
		add_row(FN_JREQ, 32'd0, 16'd0, 32'd0, 32'h8000_0000, 1'b1, ST_APPENDED);
		// A join reply carrying this node's own id joins without an append.
		add_row(FN_JREP, 32'd0, 16'd9, 32'd2, 32'd0, 1'b1, ST_OWN_ID);
		add_row(FN_JREP, 32'd7, 16'd1234, 32'd3, 32'd0, 1'b1, ST_APPENDED);
		// The entry stamped with the most negative value expires on this tick.
		add_row(FN_TICK, 32'd0, 16'd0, 32'd0, 32'd0, 1'b1, ST_TICK);
		add_row(FN_GOSSIP, 32'd7, 16'd1, 32'd10, 32'd0, 1'b1, ST_UPDATED);
		add_row(FN_GOSSIP, 32'd7, 16'd1, 32'd10, 32'd0, 1'b1, ST_UNCHANGED);
		add_row(FN_GOSSIP, 32'd9, 16'd2, 32'd0, 32'h8000_0000, 1'b1, ST_STALE);
		// A stamp from the future has a negative age and is accepted.
		add_row(FN_GOSSIP, 32'd9, 16'd2, 32'd0, 32'h7FFF_FFFF, 1'b1, ST_APPENDED);
		// Gossip about this node raises the own heartbeat until the next tick.
		add_row(FN_GOSSIP, 32'd0, 16'd3, 32'hFFFF_FFFF, 32'd0, 1'b1, ST_UPDATED);
		add_row(FN_TICK, 32'd0, 16'd0, 32'd0, 32'd0, 1'b1, ST_TICK);
		add_row(FN_GOSSIP, 32'hFFFF_FFFF, 16'd4, 32'd0, 32'd1, 1'b1, ST_UNCHANGED);
		add_row(FN_JREP, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
			ST_TICK);
		add_row(FN_TICK, 32'd0, 16'd0, 32'd0, 32'd0, 1'b0, ST_TICK);
		foreach (dir_rows[r])
			offer_item(dir_rows[r].fn, dir_rows[r].id, dir_rows[r].port, dir_rows[r].beat,
				dir_rows[r].stamp, dir_rows[r].typed, dir_rows[r].st);
		drain();

		// Random part: each phase runs on its own register setting, extremes included.
		own_ids = '{32'd0, 32'hFFFF_FFFF, $urandom(), $urandom(), 32'd12, $urandom()};
		fail_lims = '{16'd0, 16'hFFFF, 16'd3, 16'd12, 16'd1, 16'($urandom())};
		remove_lims = '{16'hFFFF, 16'd0, 16'd25, 16'd6, 16'd60, 16'd2};
		per_phase = RAND_ITEMS / PHASES;
		for (int p = 0; p < PHASES; p++) begin
			reg_write(REG_OWN_ID, own_ids[p]);
			reg_write(REG_OWN_PORT, (p == 1) ? 32'h0000_FFFF : $urandom());
			reg_write(REG_INTRO_ID, (p % 2 == 0) ? own_ids[p] : $urandom());
			reg_write(REG_FAIL_LIM, 32'(fail_lims[p]));
			reg_write(REG_REMOVE_LIM, 32'(remove_lims[p]));
			@(posedge clk);
			for (int n = 0; n < per_phase; n++) begin
				// During the third phase the receiver holds off while items keep coming.
				if (p == 2 && n == 100)
					hold_long = 1'b1;
				offer_random();
			end
			drain();
		end

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[heartbeat_membership_table.f]
hdl/hbmt_pkg.sv
hdl/hbmt_ram.sv
hdl/hbmt_front.sv
hdl/hbmt_back.sv
hdl/heartbeat_membership_table.sv
sim/tb_heartbeat_membership_table.sv
